FILE: src/rbst_pkg.sv
// Package for the ring buffer span tracker: widths, command and register codes,
// and the item, result, state and configuration types.
// No dependencies.
package rbst_pkg;

   localparam int INDEX_WIDTH = 16;
   localparam int CNT_W       = INDEX_WIDTH + 1;
   localparam int SPAN_CNT_W  = 2;

   localparam logic [CNT_W-1:0] MAX_CAP = CNT_W'(1) << INDEX_WIDTH;
   localparam logic [SPAN_CNT_W-1:0] SPAN_LIMIT_RESET = SPAN_CNT_W'(2);

   typedef enum logic [1:0] {
      CMD_QUERY   = 2'd0,
      CMD_PRODUCE = 2'd1,
      CMD_CONSUME = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_CAPACITY   = 1'b0,
      CSR_SPAN_LIMIT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      cmd_type          command;
      logic [CNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] read_position;
      logic [INDEX_WIDTH-1:0] write_position;
      logic [CNT_W-1:0]       stored_bytes;
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] capacity;
      logic             lim_any;
      logic             lim_two;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]       applied_amount;
      logic [CNT_W-1:0]       fill_level;
      logic [SPAN_CNT_W-1:0]  read_span_count;
      logic [INDEX_WIDTH-1:0] read_first_offset;
      logic [CNT_W-1:0]       read_first_length;
      logic [INDEX_WIDTH-1:0] read_second_offset;
      logic [CNT_W-1:0]       read_second_length;
      logic [SPAN_CNT_W-1:0]  write_span_count;
      logic [INDEX_WIDTH-1:0] write_first_offset;
      logic [CNT_W-1:0]       write_first_length;
      logic [INDEX_WIDTH-1:0] write_second_offset;
      logic [CNT_W-1:0]       write_second_length;
   } rsp_type;

endpackage

FILE: src/rbst_ifs.sv
// Channel interfaces of the ring buffer span tracker: command items, result
// items and register writes. Depends on rbst_pkg.
interface rbst_req_if;
   logic                           valid;
   logic                           ready;
   rbst_pkg::cmd_type              command;
   logic [rbst_pkg::CNT_W-1:0]     amount;

   modport source (output valid, command, amount, input ready);
   modport sink   (input valid, command, amount, output ready);
endinterface

interface rbst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rbst_pkg::CNT_W-1:0]         applied_amount;
   logic [rbst_pkg::CNT_W-1:0]         fill_level;
   logic [rbst_pkg::SPAN_CNT_W-1:0]    read_span_count;
   logic [rbst_pkg::INDEX_WIDTH-1:0]   read_first_offset;
   logic [rbst_pkg::CNT_W-1:0]         read_first_length;
   logic [rbst_pkg::INDEX_WIDTH-1:0]   read_second_offset;
   logic [rbst_pkg::CNT_W-1:0]         read_second_length;
   logic [rbst_pkg::SPAN_CNT_W-1:0]    write_span_count;
   logic [rbst_pkg::INDEX_WIDTH-1:0]   write_first_offset;
   logic [rbst_pkg::CNT_W-1:0]         write_first_length;
   logic [rbst_pkg::INDEX_WIDTH-1:0]   write_second_offset;
   logic [rbst_pkg::CNT_W-1:0]         write_second_length;

   modport source (output valid, applied_amount, fill_level, read_span_count,
                   read_first_offset, read_first_length, read_second_offset,
                   read_second_length, write_span_count, write_first_offset,
                   write_first_length, write_second_offset, write_second_length,
                   input ready);
   modport sink   (input valid, applied_amount, fill_level, read_span_count,
                   read_first_offset, read_first_length, read_second_offset,
                   read_second_length, write_span_count, write_first_offset,
                   write_first_length, write_second_offset, write_second_length,
                   output ready);
endinterface

interface rbst_csr_if;
   logic                         valid;
   logic                         ready;
   rbst_pkg::csr_idx_type        index;
   logic [rbst_pkg::CNT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/rbst_step.sv
// Next-state and result logic for one command item: clamping, index wrap
// and span extraction. Purely combinational. Depends on rbst_pkg.
module rbst_step (
   input  rbst_pkg::req_type   item,
   input  rbst_pkg::state_type cur,
   input  rbst_pkg::cfg_type   cfg,
   output rbst_pkg::state_type nxt,
   output rbst_pkg::rsp_type   res
);
   import rbst_pkg::*;

   logic [CNT_W-1:0]       cap;
   logic [CNT_W-1:0]       room;
   logic [CNT_W-1:0]       applied;
   logic [CNT_W-1:0]       base;
   logic [CNT_W-1:0]       sum;
   logic [INDEX_WIDTH-1:0] wrapped;
   logic [CNT_W-1:0]       rp_w;
   logic [CNT_W-1:0]       wp_w;

   assign cap     = cfg.capacity;
   assign room    = cap - cur.stored_bytes;
   assign base    = (item.command == CMD_PRODUCE) ? CNT_W'(cur.write_position)
                                                  : CNT_W'(cur.read_position);
   assign sum     = base + applied;
   assign wrapped = (sum >= cap) ? INDEX_WIDTH'(sum - cap) : INDEX_WIDTH'(sum);

   always_comb begin
      unique case (item.command)
         CMD_PRODUCE: applied = (item.amount < room) ? item.amount : room;
         CMD_CONSUME: applied = (item.amount < cur.stored_bytes) ? item.amount
                                                                 : cur.stored_bytes;
         default:     applied = '0;
      endcase
   end

   always_comb begin
      nxt = cur;
      unique case (item.command)
         CMD_QUERY: begin
         end
         CMD_PRODUCE: begin
            nxt.write_position = wrapped;
            nxt.stored_bytes   = cur.stored_bytes + applied;
         end
         CMD_CONSUME: begin
            nxt.read_position = wrapped;
            nxt.stored_bytes  = cur.stored_bytes - applied;
            if (nxt.stored_bytes == '0) begin
               nxt.read_position  = '0;
               nxt.write_position = '0;
            end
         end
         CMD_CLEAR: begin
            nxt = '0;
         end
         default: begin
         end
      endcase
   end

   assign rp_w = CNT_W'(nxt.read_position);
   assign wp_w = CNT_W'(nxt.write_position);

   always_comb begin
      res                = '0;
      res.applied_amount = applied;
      res.fill_level     = nxt.stored_bytes;
      if (cfg.lim_any && nxt.stored_bytes != '0) begin
         res.read_span_count   = SPAN_CNT_W'(1);
         res.read_first_offset = nxt.read_position;
         if (rp_w < wp_w) begin
            res.read_first_length = wp_w - rp_w;
         end else begin
            res.read_first_length = cap - rp_w;
            if (wp_w != '0 && cfg.lim_two) begin
               res.read_span_count    = SPAN_CNT_W'(2);
               res.read_second_length = wp_w;
            end
         end
      end
      if (cfg.lim_any && nxt.stored_bytes != cap) begin
         res.write_span_count   = SPAN_CNT_W'(1);
         res.write_first_offset = nxt.write_position;
         if (wp_w >= rp_w) begin
            res.write_first_length = cap - wp_w;
            if (rp_w != '0 && cfg.lim_two) begin
               res.write_span_count    = SPAN_CNT_W'(2);
               res.write_second_length = rp_w;
            end
         end else begin
            res.write_first_length = rp_w - wp_w;
         end
      end
   end

endmodule

FILE: src/ring_buffer_span_tracker_top.sv
// Top level of the ring buffer span tracker: input register, state and
// configuration registers, result register. Depends on rbst_pkg, rbst_ifs, rbst_step.
//
// Tracks read index, write index and fill count of a circular byte buffer and
// answers each command item (query, produce, consume, clear) with one result
// item: applied amount, fill level and up to two readable and two writable
// spans. An item is registered on acceptance and resolved from that register into
// the result register; one item is accepted every cycle unless the result side
// stalls, and the single read-modify-write of the index state per cycle sets that rate.
// Register writes are taken at any time with csr ready always high and must
// only occur while no item is in flight; writing the capacity empties the buffer.
module ring_buffer_span_tracker_top (
   input logic         clock,
   input logic         reset,
   rbst_req_if.sink    req_if,
   rbst_rsp_if.source  rsp_if,
   rbst_csr_if.sink    csr_if
);
   import rbst_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      capacity_ff;
   logic [SPAN_CNT_W-1:0] span_limit_ff;
   cfg_type               cfg;
   rsp_type               res;
   logic                  advance;
   logic                  req_take;
   logic                  cap_write;

   assign cfg.capacity = (capacity_ff == '0 || capacity_ff > MAX_CAP) ? MAX_CAP : capacity_ff;
   assign cfg.lim_any  = |span_limit_ff;
   assign cfg.lim_two  = span_limit_ff[SPAN_CNT_W-1];

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take  = req_if.valid && req_if.ready;
   assign cap_write = csr_if.valid && csr_if.index == CSR_CAPACITY;

   assign req_if.ready = !in_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   rbst_step u_step (
      .item (in_item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (res)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         capacity_ff   <= MAX_CAP;
         span_limit_ff <= SPAN_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         priority if (cap_write) begin
            state_ff <= '0;
         end else if (advance) begin
            state_ff <= state_in;
         end
         if (csr_if.valid) begin
            unique case (csr_if.index)
               CSR_CAPACITY:   capacity_ff   <= csr_if.data;
               CSR_SPAN_LIMIT: span_limit_ff <= csr_if.data[SPAN_CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command <= req_if.command;
         in_item_ff.amount  <= req_if.amount;
      end
      if (advance) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.applied_amount      = rsp_data_ff.applied_amount;
   assign rsp_if.fill_level          = rsp_data_ff.fill_level;
   assign rsp_if.read_span_count     = rsp_data_ff.read_span_count;
   assign rsp_if.read_first_offset   = rsp_data_ff.read_first_offset;
   assign rsp_if.read_first_length   = rsp_data_ff.read_first_length;
   assign rsp_if.read_second_offset  = rsp_data_ff.read_second_offset;
   assign rsp_if.read_second_length  = rsp_data_ff.read_second_length;
   assign rsp_if.write_span_count    = rsp_data_ff.write_span_count;
   assign rsp_if.write_first_offset  = rsp_data_ff.write_first_offset;
   assign rsp_if.write_first_length  = rsp_data_ff.write_first_length;
   assign rsp_if.write_second_offset = rsp_data_ff.write_second_offset;
   assign rsp_if.write_second_length = rsp_data_ff.write_second_length;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.stored_bytes <= cfg.capacity)
      else $error("fill count above capacity");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(state_ff.read_position) < cfg.capacity &&
      CNT_W'(state_ff.write_position) < cfg.capacity)
      else $error("index outside capacity");

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      state_ff.stored_bytes == '0 |->
      state_ff.read_position == '0 && state_ff.write_position == '0)
      else $error("empty buffer with nonzero index");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_data_ff.fill_level == $past(state_in.stored_bytes))
      else $error("resolved item not presented");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for ring_buffer_span_tracker_top: an opening command table, then random
// query/produce/consume/clear phases under varied capacity and span limit settings.
// Depends on rbst_pkg, rbst_ifs and the tracker RTL.
module tb;
   import rbst_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_GOAL   = 1750;
   localparam int REPORT_MAX  = 10;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      cmd_type          command;
      csr_idx_type      reg_sel;
      logic [CNT_W-1:0] value;
      logic             pinned;
      logic [CNT_W-1:0] pin_applied;
      logic [CNT_W-1:0] pin_fill;
   } script_row_type;

   // pinned rows carry applied amount and fill level worked out by hand
   localparam script_row_type OPENING_ROWS [30] = '{
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b1, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd65536,  1'b1, 17'd65536, 17'd65536},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd1,      1'b1, 17'd0,     17'd65536},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'h1FFFF,  1'b1, 17'd65536, 17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd0,      1'b1, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'd0,      1'b1, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd100,    1'b1, 17'd100,   17'd100},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'd30,     1'b1, 17'd30,    17'd70},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_CLEAR,   CSR_CAPACITY,   17'd5,      1'b1, 17'd0,     17'd0},
      '{ROW_CSR,  CMD_QUERY,   CSR_CAPACITY,   17'd5,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd3,      1'b1, 17'd3,     17'd3},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'd2,      1'b1, 17'd2,     17'd1},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd4,      1'b1, 17'd4,     17'd5},
      '{ROW_CSR,  CMD_QUERY,   CSR_SPAN_LIMIT, 17'd1,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'd4,      1'b1, 17'd4,     17'd1},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd3,      1'b0, 17'd0,     17'd0},
      '{ROW_CSR,  CMD_QUERY,   CSR_SPAN_LIMIT, 17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_CSR,  CMD_QUERY,   CSR_SPAN_LIMIT, 17'h1FFFF,  1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_CSR,  CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd65535,  1'b1, 17'd65535, 17'd65535},
      '{ROW_CSR,  CMD_QUERY,   CSR_CAPACITY,   17'h1FFFF,  1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b1, 17'd0,     17'd0},
      '{ROW_CSR,  CMD_QUERY,   CSR_CAPACITY,   17'd1,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_PRODUCE, CSR_CAPACITY,   17'd2,      1'b1, 17'd1,     17'd1},
      '{ROW_ITEM, CMD_QUERY,   CSR_CAPACITY,   17'd0,      1'b0, 17'd0,     17'd0},
      '{ROW_ITEM, CMD_CONSUME, CSR_CAPACITY,   17'd1,      1'b1, 17'd1,     17'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbst_req_if req_ch ();
   rbst_rsp_if rsp_ch ();
   rbst_csr_if csr_ch ();

   ring_buffer_span_tracker_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #1 clock = ~clock;

   // mirror of the tracker: registers and ring state
   logic [CNT_W-1:0] cap_reg = MAX_CAP;
   logic [1:0]       lim_reg = SPAN_LIMIT_RESET;
   int unsigned      rd_idx = 0;
   int unsigned      wr_idx = 0;
   int unsigned      fill = 0;

   rsp_type span_reports_due [$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      quiet_cycles = 0;
   int      hold_left = 0;
   bit      send_idle = 1'b0;
   bit      recv_idle = 1'b0;

   function automatic int unsigned eff_capacity(logic [CNT_W-1:0] c);
      return 32'((c == '0 || c > MAX_CAP) ? MAX_CAP : c);
   endfunction

   function automatic rsp_type advance_ring(cmd_type c, logic [CNT_W-1:0] a);
      int unsigned cap;
      int unsigned lim;
      int unsigned moved;
      int unsigned pos;
      rsp_type     r;
      cap   = eff_capacity(cap_reg);
      lim   = (lim_reg > 2'd2) ? 2 : 32'(lim_reg);
      moved = 0;
      r     = '0;
      case (c)
         CMD_PRODUCE: begin
            moved = (a < cap - fill) ? a : cap - fill;
            pos = wr_idx + moved;
            if (pos >= cap) pos -= cap;
            wr_idx = pos;
            fill += moved;
         end
         CMD_CONSUME: begin
            moved = (a < fill) ? a : fill;
            pos = rd_idx + moved;
            if (pos >= cap) pos -= cap;
            rd_idx = pos;
            fill -= moved;
            if (fill == 0) begin
               rd_idx = 0;
               wr_idx = 0;
            end
         end
         CMD_CLEAR: begin
            rd_idx = 0;
            wr_idx = 0;
            fill   = 0;
         end
         default: ;
      endcase
      r.applied_amount = CNT_W'(moved);
      r.fill_level     = CNT_W'(fill);
      if (lim > 0 && fill != 0) begin
         r.read_span_count   = SPAN_CNT_W'(1);
         r.read_first_offset = INDEX_WIDTH'(rd_idx);
         if (rd_idx < wr_idx) begin
            r.read_first_length = CNT_W'(wr_idx - rd_idx);
         end else begin
            r.read_first_length = CNT_W'(cap - rd_idx);
            if (wr_idx > 0 && lim >= 2) begin
               r.read_span_count    = SPAN_CNT_W'(2);
               r.read_second_length = CNT_W'(wr_idx);
            end
         end
      end
      if (lim > 0 && fill != cap) begin
         r.write_span_count   = SPAN_CNT_W'(1);
         r.write_first_offset = INDEX_WIDTH'(wr_idx);
         if (wr_idx >= rd_idx) begin
            r.write_first_length = CNT_W'(cap - wr_idx);
            if (rd_idx > 0 && lim >= 2) begin
               r.write_span_count    = SPAN_CNT_W'(2);
               r.write_second_length = CNT_W'(rd_idx);
            end
         end else begin
            r.write_first_length = CNT_W'(rd_idx - wr_idx);
         end
      end
      return r;
   endfunction

   function automatic void log_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("tb: mismatch: %s", what);
   endfunction

   function automatic void compare_field(string name, logic [CNT_W-1:0] exp_v,
                                         logic [CNT_W-1:0] got_v);
      if (got_v !== exp_v)
         log_mismatch($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
   endfunction

   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      while (span_reports_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type sel, logic [CNT_W-1:0] v);
      drain_pipe();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= sel;
      csr_ch.data  <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (sel == CSR_CAPACITY) begin
         cap_reg = v;
         rd_idx  = 0;
         wr_idx  = 0;
         fill    = 0;
      end else begin
         lim_reg = v[1:0];
      end
   endtask

   task automatic send_item(cmd_type c, logic [CNT_W-1:0] a, logic pinned,
                            logic [CNT_W-1:0] pin_applied, logic [CNT_W-1:0] pin_fill);
      rsp_type due;
      if (send_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= c;
      req_ch.amount  <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      due = advance_ring(c, a);
      if (pinned) begin
         due.applied_amount = pin_applied;
         due.fill_level     = pin_fill;
      end
      span_reports_due.push_back(due);
      items_sent++;
   endtask

   // result sink with random back-pressure bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 8);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      rsp_type got;
      rsp_type due;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.applied_amount, rsp_ch.fill_level, rsp_ch.read_span_count,
                   rsp_ch.read_first_offset, rsp_ch.read_first_length,
                   rsp_ch.read_second_offset, rsp_ch.read_second_length,
                   rsp_ch.write_span_count, rsp_ch.write_first_offset,
                   rsp_ch.write_first_length, rsp_ch.write_second_offset,
                   rsp_ch.write_second_length};
            if (span_reports_due.size() == 0) begin
               log_mismatch("result item with nothing expected");
            end else begin
               due = span_reports_due.pop_front();
               compare_field("applied_amount", due.applied_amount, got.applied_amount);
               compare_field("fill_level", due.fill_level, got.fill_level);
               compare_field("read_span_count", due.read_span_count, got.read_span_count);
               compare_field("read_first_offset", due.read_first_offset,
                             got.read_first_offset);
               compare_field("read_first_length", due.read_first_length,
                             got.read_first_length);
               compare_field("read_second_offset", due.read_second_offset,
                             got.read_second_offset);
               compare_field("read_second_length", due.read_second_length,
                             got.read_second_length);
               compare_field("write_span_count", due.write_span_count,
                             got.write_span_count);
               compare_field("write_first_offset", due.write_first_offset,
                             got.write_first_offset);
               compare_field("write_first_length", due.write_first_length,
                             got.write_first_length);
               compare_field("write_second_offset", due.write_second_offset,
                             got.write_second_offset);
               compare_field("write_second_length", due.write_second_length,
                             got.write_second_length);
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned      cap;
      int unsigned      left;
      int unsigned      lot;
      int unsigned      pick;
      bit               last;
      cmd_type          cmd;
      logic [CNT_W-1:0] amt;
      logic [CNT_W-1:0] cap_data;
      logic [CNT_W-1:0] lim_data;

      req_ch.valid   = 1'b0;
      req_ch.command = CMD_QUERY;
      req_ch.amount  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_CAPACITY;
      csr_ch.data    = '0;
      rsp_ch.ready   = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle = 1'b1;
      recv_idle = 1'b1;
      foreach (OPENING_ROWS[i]) begin
         if (OPENING_ROWS[i].kind == ROW_CSR) begin
            write_reg(OPENING_ROWS[i].reg_sel, OPENING_ROWS[i].value);
         end else begin
            send_item(OPENING_ROWS[i].command, OPENING_ROWS[i].value,
                      OPENING_ROWS[i].pinned, OPENING_ROWS[i].pin_applied,
                      OPENING_ROWS[i].pin_fill);
         end
      end

      // random phases; each starts from an empty buffer after a full drain
      while (items_sent < ITEM_GOAL) begin
         left = ITEM_GOAL - items_sent;
         last = (left <= 200);
         send_idle = !last && $urandom_range(0, 3) != 0;
         recv_idle = !last && $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 9))
            0: cap_data = MAX_CAP;
            1: cap_data = '0;
            2: cap_data = CNT_W'($urandom_range(MAX_CAP + 1, (1 << CNT_W) - 1));
            3: cap_data = CNT_W'($urandom_range(1, MAX_CAP));
            default: cap_data = CNT_W'($urandom_range(1, 16));
         endcase
         write_reg(CSR_CAPACITY, cap_data);
         lim_data = CNT_W'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 0) lim_data = lim_data | (CNT_W'($urandom) & 17'h1FFFC);
         write_reg(CSR_SPAN_LIMIT, lim_data);
         cap = eff_capacity(cap_data);
         lot = last ? left : $urandom_range(40, 150);
         if (lot > left) lot = left;
         repeat (lot) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) cmd = CMD_CLEAR;
            else if (pick < 3) cmd = CMD_QUERY;
            else if (pick < 12) cmd = CMD_PRODUCE;
            else cmd = CMD_CONSUME;
            case ($urandom_range(0, 15))
               0: amt = CNT_W'($urandom);
               1: amt = '0;
               2: amt = CNT_W'(cap);
               default: amt = CNT_W'($urandom_range(0, cap));
            endcase
            send_item(cmd, amt, 1'b0, '0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (span_reports_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && span_reports_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
